// File: hw/rtl/icl_pkg.sv
package icl_pkg;

   // default table size
   localparam int ENTRIES_DEFAULT = 16;

   // request function codes
   localparam logic [2:0] FUNC_GET         = 3'd0;
   localparam logic [2:0] FUNC_FILL_FAILED = 3'd1;
   localparam logic [2:0] FUNC_RELEASE     = 3'd2;
   localparam logic [2:0] FUNC_UNLOCK      = 3'd3;
   localparam logic [2:0] FUNC_LOCK        = 3'd4;

   // response status codes
   localparam logic [2:0] STATUS_HIT  = 3'd0;
   localparam logic [2:0] STATUS_MISS = 3'd1;
   localparam logic [2:0] STATUS_BUSY = 3'd2;
   localparam logic [2:0] STATUS_FULL = 3'd3;
   localparam logic [2:0] STATUS_DONE = 3'd4;
   localparam logic [2:0] STATUS_BAD  = 3'd5;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] device;
      logic [31:0] inode_number;
      logic [3:0]  slot;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] result_slot;
      logic       wake_waiters;
   } rsp_word_type;

endpackage

// File: hw/rtl/icl_chan_if.sv
interface icl_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// File: hw/rtl/inode_cache_lru_free_list_unit.sv
// Channel   Dir  Word           Handshake
// req_ch    in   req_word_type  valid/ready, taken when both high
// rsp_ch    out  rsp_word_type  valid/ready, taken when both high
//
// One request at a time. fill_failed, release, unlock and lock go from the
// execute state straight to the response. get scans the tag store one entry
// per cycle over one compare unit; when the slot leaves the free queue (a hit
// slot is found first), later words move down one per cycle through one port.
// After reset a pass writes each slot index into the free queue; req_ch is not
// ready meanwhile. A stalled response holds until rsp_ch takes it.
module inode_cache_lru_free_list_unit
   import icl_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   icl_chan_if.sink    req_ch,
   icl_chan_if.source  rsp_ch
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [8:0] {
      ST_INIT   = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_EXEC   = 9'b000000100,
      ST_SEARCH = 9'b000001000,
      ST_HEAD   = 9'b000010000,
      ST_HEADW  = 9'b000100000,
      ST_FIND   = 9'b001000000,
      ST_SHIFT  = 9'b010000000,
      ST_RESP   = 9'b100000000
   } state_type;

   state_type    state_ff, state_in;
   req_word_type req_ff, req_in;
   rsp_word_type res_ff, res_in;
   rsp_word_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] scan_ff, scan_in;
   logic [CW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] target_ff, target_in;
   logic [CW-1:0] count_ff, count_in;

   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] locked_ff, locked_in;
   logic [ENTRIES-1:0] ref_ff, ref_in;
   logic [ENTRIES-1:0] wanted_ff, wanted_in;

   // tag store and free queue memories
   logic [47:0]   tag_mem [ENTRIES];
   logic [IW-1:0] queue_mem [ENTRIES];
   logic [47:0]   tag_rd_ff;
   logic [IW-1:0] q_rd_ff;

   logic          tag_we;
   logic [IW-1:0] tag_waddr;
   logic [IW-1:0] tag_raddr;
   logic          q_we;
   logic [IW-1:0] q_waddr;
   logic [IW-1:0] q_wdata;
   logic [IW-1:0] q_raddr;

   logic [IW-1:0] sidx;
   logic [IW-1:0] cidx;
   logic          in_range;
   logic          tag_match;
   logic          queue_match;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.word  = rsp_ff;

   assign sidx        = IW'(req_ff.slot);
   assign cidx        = IW'(cmp_idx_ff);
   assign in_range    = (32'(req_ff.slot) < ENTRIES);
   assign tag_match   = pend_ff && valid_ff[cidx]
                        && (tag_rd_ff == {req_ff.device, req_ff.inode_number});
   assign queue_match = pend_ff && (q_rd_ff == target_ff);

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[tag_waddr] <= {req_ff.device, req_ff.inode_number};
      end
      tag_rd_ff <= tag_mem[tag_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      q_rd_ff <= queue_mem[q_raddr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      pend_in      = 1'b0;
      target_in    = target_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      locked_in    = locked_ff;
      ref_in       = ref_ff;
      wanted_in    = wanted_ff;
      tag_we       = 1'b0;
      tag_waddr    = q_rd_ff;
      tag_raddr    = IW'(scan_ff);
      q_we         = 1'b0;
      q_waddr      = IW'(count_ff);
      q_wdata      = sidx;
      q_raddr      = IW'(scan_ff);

      // output register drains independently
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            q_we    = 1'b1;
            q_waddr = IW'(scan_ff);
            q_wdata = IW'(scan_ff);
            if (scan_ff == CW'(ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end

         ST_IDLE: begin
            if (req_ch.valid) begin
               req_in   = req_ch.word;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            res_in.status       = STATUS_BAD;
            res_in.result_slot  = req_ff.slot;
            res_in.wake_waiters = 1'b0;
            state_in            = ST_RESP;
            unique case (req_ff.func)
               FUNC_GET: begin
                  scan_in  = '0;
                  state_in = ST_SEARCH;
               end
               FUNC_FILL_FAILED: begin
                  if (in_range && locked_ff[sidx] && ref_ff[sidx]) begin
                     res_in.wake_waiters = wanted_ff[sidx];
                     res_in.status       = STATUS_DONE;
                     valid_in[sidx]      = 1'b0;
                     locked_in[sidx]     = 1'b0;
                     ref_in[sidx]        = 1'b0;
                     wanted_in[sidx]     = 1'b0;
                     if (count_ff < CW'(ENTRIES)) begin
                        q_we     = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               FUNC_RELEASE: begin
                  if (in_range && !locked_ff[sidx] && ref_ff[sidx]) begin
                     res_in.status   = STATUS_DONE;
                     locked_in[sidx] = 1'b0;
                     ref_in[sidx]    = 1'b0;
                     wanted_in[sidx] = 1'b0;
                     if (count_ff < CW'(ENTRIES)) begin
                        q_we     = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end
               FUNC_UNLOCK: begin
                  if (in_range && locked_ff[sidx]) begin
                     res_in.status       = STATUS_DONE;
                     res_in.wake_waiters = wanted_ff[sidx];
                     locked_in[sidx]     = 1'b0;
                     wanted_in[sidx]     = 1'b0;
                  end
               end
               FUNC_LOCK: begin
                  if (in_range) begin
                     if (locked_ff[sidx]) begin
                        res_in.status   = STATUS_BUSY;
                        wanted_in[sidx] = 1'b1;
                     end else begin
                        res_in.status   = STATUS_DONE;
                        locked_in[sidx] = 1'b1;
                     end
                  end
               end
               default: begin
                  res_in.status = STATUS_BAD;
               end
            endcase
         end

         // one tag read issued and one compared per cycle
         ST_SEARCH: begin
            if (tag_match) begin
               res_in.result_slot = 4'(cidx);
               if (locked_ff[cidx]) begin
                  res_in.status   = STATUS_BUSY;
                  wanted_in[cidx] = 1'b1;
                  state_in        = ST_RESP;
               end else begin
                  res_in.status   = STATUS_HIT;
                  locked_in[cidx] = 1'b1;
                  ref_in[cidx]    = 1'b1;
                  if (!ref_ff[cidx]) begin
                     target_in = cidx;
                     scan_in   = '0;
                     state_in  = ST_FIND;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
            end else if (scan_ff >= CW'(ENTRIES)) begin
               if (count_ff == '0) begin
                  res_in.status      = STATUS_FULL;
                  res_in.result_slot = 4'd0;
                  state_in           = ST_RESP;
               end else begin
                  state_in = ST_HEAD;
               end
            end else begin
               scan_in    = scan_ff + CW'(1);
               cmp_idx_in = scan_ff;
               pend_in    = 1'b1;
            end
         end

         // read the queue head
         ST_HEAD: begin
            q_raddr  = '0;
            state_in = ST_HEADW;
         end

         // retag the head slot, then close the gap at queue position zero
         ST_HEADW: begin
            tag_we                = 1'b1;
            tag_waddr             = q_rd_ff;
            valid_in[q_rd_ff]     = 1'b1;
            locked_in[q_rd_ff]    = 1'b1;
            ref_in[q_rd_ff]       = 1'b1;
            wanted_in[q_rd_ff]    = 1'b0;
            res_in.status         = STATUS_MISS;
            res_in.result_slot    = 4'(q_rd_ff);
            scan_in               = CW'(1);
            state_in              = ST_SHIFT;
         end

         // locate the hit slot in the free queue
         ST_FIND: begin
            if (queue_match) begin
               scan_in  = cmp_idx_ff + CW'(1);
               state_in = ST_SHIFT;
            end else if (scan_ff >= count_ff) begin
               state_in = ST_RESP;
            end else begin
               scan_in    = scan_ff + CW'(1);
               cmp_idx_in = scan_ff;
               pend_in    = 1'b1;
            end
         end

         // move each later word down by one position
         ST_SHIFT: begin
            if (pend_ff) begin
               q_we    = 1'b1;
               q_waddr = IW'(cmp_idx_ff - CW'(1));
               q_wdata = q_rd_ff;
            end
            if (scan_ff < count_ff) begin
               scan_in    = scan_ff + CW'(1);
               cmp_idx_in = scan_ff;
               pend_in    = 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= CW'(ENTRIES);
         valid_ff     <= '0;
         locked_ff    <= '0;
         ref_ff       <= '0;
         wanted_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         locked_ff    <= locked_in;
         ref_ff       <= ref_in;
         wanted_ff    <= wanted_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      cmp_idx_ff <= cmp_idx_in;
      target_ff  <= target_in;
   end

endmodule
